[src/fdse_pkg.sv]
// ----------------------------------------------------------------------------
// fdse_pkg: shared types and codes for the Forth data stack executor
// Word codes, result kinds and the controller-to-datapath command struct.
// ----------------------------------------------------------------------------
package fdse_pkg;

  localparam int ModeW  = 5;
  localparam int KindW  = 3;
  localparam int LitW   = 32;
  localparam int ValueW = 32;
  localparam int MaxResults = 64;

  localparam logic [ModeW-1:0] W_LIT  = 5'd0;
  localparam logic [ModeW-1:0] W_PRT  = 5'd1;
  localparam logic [ModeW-1:0] W_DROP = 5'd2;
  localparam logic [ModeW-1:0] W_DUP  = 5'd3;
  localparam logic [ModeW-1:0] W_SWAP = 5'd4;
  localparam logic [ModeW-1:0] W_OVER = 5'd5;
  localparam logic [ModeW-1:0] W_ROT  = 5'd6;
  localparam logic [ModeW-1:0] W_ADD  = 5'd7;
  localparam logic [ModeW-1:0] W_SUB  = 5'd8;
  localparam logic [ModeW-1:0] W_MUL  = 5'd9;
  localparam logic [ModeW-1:0] W_DIV  = 5'd10;
  localparam logic [ModeW-1:0] W_EQ   = 5'd11;
  localparam logic [ModeW-1:0] W_LT   = 5'd12;
  localparam logic [ModeW-1:0] W_GT   = 5'd13;
  localparam logic [ModeW-1:0] W_DUMP = 5'd14;
  localparam logic [ModeW-1:0] W_EMIT = 5'd15;
  localparam logic [ModeW-1:0] W_CR   = 5'd16;

  localparam logic [KindW-1:0] K_DONE  = 3'd0;
  localparam logic [KindW-1:0] K_PRINT = 3'd1;
  localparam logic [KindW-1:0] K_CHAR  = 3'd2;
  localparam logic [KindW-1:0] K_DUMP  = 3'd3;
  localparam logic [KindW-1:0] K_CR    = 3'd4;
  localparam logic [KindW-1:0] K_SKIP  = 3'd5;

  // datapath commands
  typedef enum logic [3:0] {
    C_NOP, C_POP_A, C_POP_B, C_POP_C, C_RD_WAIT, C_PUSH, C_DIV_GO, C_DUMP_RD
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [2:0]       src;   // push source select
  } dp_cmd_t;

  localparam logic [2:0] S_LIT = 3'd0;
  localparam logic [2:0] S_A   = 3'd1;
  localparam logic [2:0] S_B   = 3'd2;
  localparam logic [2:0] S_C   = 3'd3;
  localparam logic [2:0] S_RES = 3'd4;

  typedef struct packed {
    logic div_busy;
    logic a_zero;
  } dp_stat_t;

endpackage

[src/fdse_datapath.sv]
// ----------------------------------------------------------------------------
// fdse_datapath: stack memory, operand registers, ALU and divider
// Executes one command per cycle from the controller.
// ----------------------------------------------------------------------------
module fdse_datapath #(
  parameter int STACK_DEPTH = 64,
  parameter int CELL_WIDTH  = 32,
  parameter int CntW        = $clog2(STACK_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fdse_pkg::dp_cmd_t            cmd,
  input  logic [fdse_pkg::ModeW-1:0]   mode,
  input  logic [fdse_pkg::LitW-1:0]    lit,
  input  logic                         div_start,
  input  logic [CntW-1:0]              dump_idx,
  output fdse_pkg::dp_stat_t           stat,
  output logic [CntW-1:0]              count,
  output logic [CELL_WIDTH-1:0]        a_val,
  output logic [CELL_WIDTH-1:0]        rd_val
);
  import fdse_pkg::*;

  localparam int AddrW = $clog2(STACK_DEPTH);

  logic [CELL_WIDTH-1:0] mem [STACK_DEPTH];
  logic [CntW-1:0]       cnt_r;
  logic [CELL_WIDTH-1:0] rd_r, a_r, b_r, c_r, res_r;
  logic                  rd_zero_r;
  logic [1:0]            tgt_r;     // which operand the pending read lands in
  logic                  rd_pend_r;

  // divider
  logic [CELL_WIDTH-1:0] dq_r, drem_r, ddiv_r;
  logic                  dneg_r, dbusy_r;
  logic [$clog2(CELL_WIDTH+1)-1:0] dcnt_r;

  logic [CELL_WIDTH-1:0] push_v, alu_v, a_abs, b_abs;
  logic [CELL_WIDTH-1:0] lit_ext;
  logic [CELL_WIDTH:0]   dtrial;
  logic                  do_push;
  logic [CELL_WIDTH-1:0] trues;
  logic [2*CELL_WIDTH-1:0] prod;

  assign trues = '1;
  assign lit_ext = CELL_WIDTH'({{(CELL_WIDTH > LitW ? CELL_WIDTH-LitW : 0){lit[LitW-1]}}, lit});
  assign prod = b_r * a_r;

  always_comb begin
    case (mode)
      W_ADD:   alu_v = b_r + a_r;
      W_SUB:   alu_v = b_r - a_r;
      W_MUL:   alu_v = prod[CELL_WIDTH-1:0];
      W_EQ:    alu_v = (a_r == b_r) ? trues : '0;
      W_LT:    alu_v = ($signed(b_r) < $signed(a_r)) ? trues : '0;
      W_GT:    alu_v = ($signed(b_r) > $signed(a_r)) ? trues : '0;
      W_DIV:   alu_v = (a_r == '0) ? '0 : (dneg_r ? -dq_r : dq_r);
      default: alu_v = '0;
    endcase
  end

  always_comb begin
    case (cmd.src)
      S_LIT:   push_v = lit_ext;
      S_A:     push_v = a_r;
      S_B:     push_v = b_r;
      S_C:     push_v = c_r;
      default: push_v = res_r;
    endcase
  end

  assign do_push = (cmd.op == C_PUSH) && (cnt_r != CntW'(STACK_DEPTH));
  assign a_abs = a_r[CELL_WIDTH-1] ? -a_r : a_r;
  assign b_abs = b_r[CELL_WIDTH-1] ? -b_r : b_r;
  assign dtrial = {drem_r, dq_r[CELL_WIDTH-1]} - {1'b0, ddiv_r};

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[cnt_r[AddrW-1:0]] <= push_v;
    end
    // hold the read data while a dump element waits for the output
    if (cmd.op == C_POP_A || cmd.op == C_POP_B || cmd.op == C_POP_C ||
        cmd.op == C_DUMP_RD) begin
      rd_r <= mem[(cmd.op == C_DUMP_RD) ? dump_idx[AddrW-1:0] : AddrW'(cnt_r - 1'b1)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      rd_pend_r <= 1'b0;
      dbusy_r   <= 1'b0;
    end else begin
      rd_pend_r <= 1'b0;
      case (cmd.op)
        C_POP_A, C_POP_B, C_POP_C: begin
          rd_zero_r <= (cnt_r == '0);
          rd_pend_r <= 1'b1;
          tgt_r     <= (cmd.op == C_POP_A) ? 2'd0 : (cmd.op == C_POP_B) ? 2'd1 : 2'd2;
          if (cnt_r != '0) begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        C_PUSH: begin
          if (do_push) begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        default: ;
      endcase
      if (rd_pend_r) begin
        case (tgt_r)
          2'd0:    a_r <= rd_zero_r ? '0 : rd_r;
          2'd1:    b_r <= rd_zero_r ? '0 : rd_r;
          default: c_r <= rd_zero_r ? '0 : rd_r;
        endcase
      end
      if (cmd.op == C_RD_WAIT) begin
        res_r <= alu_v;
      end
      // restoring divide on magnitudes, one bit per cycle
      if (div_start) begin
        dq_r    <= b_abs;
        drem_r  <= '0;
        ddiv_r  <= a_abs;
        dneg_r  <= a_r[CELL_WIDTH-1] ^ b_r[CELL_WIDTH-1];
        dcnt_r  <= '0;
        dbusy_r <= (a_r != '0);
      end else if (dbusy_r) begin
        if (!dtrial[CELL_WIDTH]) begin
          drem_r <= dtrial[CELL_WIDTH-1:0];
          dq_r   <= {dq_r[CELL_WIDTH-2:0], 1'b1};
        end else begin
          drem_r <= {drem_r[CELL_WIDTH-2:0], dq_r[CELL_WIDTH-1]};
          dq_r   <= {dq_r[CELL_WIDTH-2:0], 1'b0};
        end
        dcnt_r <= dcnt_r + 1'b1;
        if (dcnt_r == ($bits(dcnt_r))'(CELL_WIDTH - 1)) begin
          dbusy_r <= 1'b0;
        end
      end
    end
  end

  assign stat.div_busy = dbusy_r;
  assign stat.a_zero   = (a_r == '0);
  assign count  = cnt_r;
  assign a_val  = a_r;
  assign rd_val = rd_r;

endmodule

[src/fdse_ctrl.sv]
// ----------------------------------------------------------------------------
// fdse_ctrl: word sequencer
// Steps pops, the ALU or divider, pushes and result emission for one word.
// ----------------------------------------------------------------------------
module fdse_ctrl #(
  parameter int CntW = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_fire,
  input  logic [fdse_pkg::ModeW-1:0]  in_mode,
  output logic                        busy,
  output logic [fdse_pkg::ModeW-1:0]  mode,
  output fdse_pkg::dp_cmd_t           cmd,
  output logic                        div_start,
  output logic [CntW-1:0]             dump_idx,
  input  fdse_pkg::dp_stat_t          stat,
  input  logic [CntW-1:0]             count,
  // result request toward the output register
  output logic                        res_req,
  output logic [fdse_pkg::KindW-1:0]  res_kind,
  output logic                        res_from_rd,
  output logic                        res_from_a,
  output logic                        res_last,
  input  logic                        res_room
);
  import fdse_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_POP1, ST_POP2, ST_POP3, ST_WAIT, ST_DIVW, ST_ALU, ST_PUSH,
    ST_EMIT, ST_DRD, ST_DOUT
  } st_t;

  st_t              st_r;
  logic [ModeW-1:0] mode_r;
  logic [2:0]       step_r;
  logic [CntW-1:0]  idx_r;
  logic [6:0]       nleft_r;

  assign busy = (st_r != ST_IDLE);
  assign mode = mode_r;
  assign dump_idx = idx_r;

  // number of pops for the word
  function automatic logic [1:0] npops(input logic [ModeW-1:0] m);
    case (m)
      W_PRT, W_DROP, W_DUP, W_EMIT: npops = 2'd1;
      W_SWAP, W_OVER, W_ADD, W_SUB, W_MUL, W_DIV, W_EQ, W_LT, W_GT: npops = 2'd2;
      W_ROT: npops = 2'd3;
      default: npops = 2'd0;
    endcase
  endfunction

  always_comb begin
    cmd = '{op: C_NOP, src: S_LIT};
    div_start = 1'b0;
    res_req = 1'b0;
    res_kind = K_DONE;
    res_from_rd = 1'b0;
    res_from_a = 1'b0;
    res_last = 1'b1;
    case (st_r)
      ST_POP1: cmd.op = C_POP_A;
      ST_POP2: cmd.op = C_POP_B;
      ST_POP3: cmd.op = C_POP_C;
      ST_WAIT: cmd.op = C_NOP;
      ST_DIVW: div_start = (step_r == 3'd0);
      ST_ALU:  cmd.op = C_RD_WAIT;
      ST_PUSH: begin
        cmd.op = C_PUSH;
        case (mode_r)
          W_LIT:  cmd.src = S_LIT;
          W_DUP:  cmd.src = S_A;
          W_SWAP: cmd.src = (step_r == 3'd0) ? S_A : S_B;
          W_OVER: cmd.src = (step_r == 3'd1) ? S_A : S_B;
          W_ROT:  cmd.src = (step_r == 3'd0) ? S_B : (step_r == 3'd1) ? S_A : S_C;
          default: cmd.src = S_RES;
        endcase
      end
      ST_DRD: cmd.op = C_DUMP_RD;
      ST_EMIT: begin
        res_req = 1'b1;
        res_from_a = 1'b1;
        case (mode_r)
          W_PRT:  res_kind = K_PRINT;
          W_EMIT: res_kind = K_SKIP;   // refined in top from value range
          W_CR:   begin res_kind = K_CR; res_from_a = 1'b0; end
          default: res_from_a = 1'b0;
        endcase
      end
      ST_DOUT: begin
        res_req = 1'b1;
        res_kind = K_DUMP;
        res_from_rd = 1'b1;
        res_last = (idx_r == '0) || (nleft_r == 7'd1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      case (st_r)
        ST_IDLE: if (in_fire) begin
          mode_r <= in_mode;
          step_r <= '0;
          if (in_mode == W_DUMP) begin
            if (count == '0) begin
              st_r <= ST_EMIT;
            end else begin
              idx_r   <= count - 1'b1;
              nleft_r <= 7'(MaxResults);
              st_r    <= ST_DRD;
            end
          end else if (in_mode == W_LIT) begin
            st_r <= ST_PUSH;
          end else if (npops(in_mode) != 2'd0) begin
            st_r <= ST_POP1;
          end else begin
            st_r <= ST_EMIT;
          end
        end
        ST_POP1: begin
          // divide by zero pops only the divisor: decided after A lands
          st_r <= (npops(mode_r) >= 2'd2 && mode_r != W_DIV) ? ST_POP2 : ST_WAIT;
        end
        ST_POP2: st_r <= (npops(mode_r) == 2'd3) ? ST_POP3 : ST_WAIT;
        ST_POP3: st_r <= ST_WAIT;
        ST_WAIT: begin
          if (mode_r == W_DIV) begin
            case (step_r)
              3'd0: step_r <= 3'd1;
              3'd1: begin
                // zero divisor: skip the dividend pop and push zero
                if (stat.a_zero) begin
                  step_r <= '0;
                  st_r   <= ST_ALU;
                end else begin
                  step_r <= 3'd2;
                  st_r   <= ST_POP2;
                end
              end
              default: begin
                step_r <= '0;
                st_r   <= ST_DIVW;
              end
            endcase
          end else begin
            case (mode_r)
              W_PRT, W_EMIT: st_r <= ST_EMIT;
              W_DROP:        st_r <= ST_EMIT;
              W_DUP, W_SWAP, W_OVER, W_ROT: st_r <= ST_PUSH;
              default:       st_r <= ST_ALU;
            endcase
          end
        end
        ST_DIVW: begin
          step_r <= 3'd1;
          if (step_r != 3'd0 && !stat.div_busy) begin
            step_r <= '0;
            st_r   <= ST_ALU;
          end
        end
        ST_ALU: st_r <= ST_PUSH;
        ST_PUSH: begin
          step_r <= step_r + 1'b1;
          if ((mode_r == W_DUP && step_r == 3'd1) ||
              (mode_r == W_SWAP && step_r == 3'd1) ||
              (mode_r == W_OVER && step_r == 3'd2) ||
              (mode_r == W_ROT && step_r == 3'd2) ||
              (mode_r != W_DUP && mode_r != W_SWAP && mode_r != W_OVER &&
               mode_r != W_ROT)) begin
            st_r <= ST_EMIT;
          end
        end
        ST_EMIT: if (res_room) begin
          st_r <= ST_IDLE;
        end
        ST_DRD: st_r <= ST_DOUT;
        ST_DOUT: if (res_room) begin
          if (res_last) begin
            st_r <= ST_IDLE;
          end else begin
            idx_r   <= idx_r - 1'b1;
            nleft_r <= nleft_r - 1'b1;
            st_r    <= ST_DRD;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

endmodule

[src/forth_data_stack_executor.sv]
// Throughput: one word at a time; the next item is taken the cycle after the word's
// last result is registered. The divider retires one quotient bit per cycle, and the
// single stack memory port sets the step count of the other words.
// Reset (rst_n low, synchronous) empties the stack; cell contents are not cleared.
// ----------------------------------------------------------------------------
// forth_data_stack_executor: top level
// Stream ports around the sequencer, datapath and output register.
// ----------------------------------------------------------------------------
module forth_data_stack_executor #(
  parameter int STACK_DEPTH = 64,
  parameter int CELL_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] literal_value
  input  logic [4:0]  in_tuser,   // [4:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] value, [38:32] depth
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast
);
  import fdse_pkg::*;

  localparam int CntW = $clog2(STACK_DEPTH + 1);

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [ModeW-1:0] mode;
  logic             busy, div_start, res_req, res_from_rd, res_from_a, res_last, res_room;
  logic [KindW-1:0] res_kind, kind_fix;
  logic [CntW-1:0]  count, dump_idx;
  logic [CELL_WIDTH-1:0] a_val, rd_val, sel_val;
  logic             in_fire;
  logic [LitW-1:0]  lit_r;

  logic             ov_r;
  logic [KindW-1:0] ok_r;
  logic [ValueW-1:0] oval_r;
  logic [6:0]       odep_r;
  logic             olast_r;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign res_room  = !ov_r || out_tready;

  // hold the literal of the accepted item for the push step
  always_ff @(posedge clk) begin
    if (in_fire) begin
      lit_r <= in_tdata;
    end
  end

  fdse_ctrl #(.CntW(CntW)) u_ctrl (
    .clk, .rst_n, .in_fire, .in_mode(in_tuser), .busy, .mode, .cmd, .div_start,
    .dump_idx, .stat, .count, .res_req, .res_kind, .res_from_rd, .res_from_a,
    .res_last, .res_room
  );

  fdse_datapath #(.STACK_DEPTH(STACK_DEPTH), .CELL_WIDTH(CELL_WIDTH), .CntW(CntW)) u_dp (
    .clk, .rst_n, .cmd, .mode, .lit(lit_r), .div_start, .dump_idx, .stat,
    .count, .a_val, .rd_val
  );

  assign sel_val = res_from_rd ? rd_val : res_from_a ? a_val : '0;

  always_comb begin
    kind_fix = res_kind;
    if (mode == W_EMIT) begin
      kind_fix = (!sel_val[CELL_WIDTH-1] && sel_val != '0 &&
                  sel_val < CELL_WIDTH'(128)) ? K_CHAR : K_SKIP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      if (out_tready) begin
        ov_r <= 1'b0;
      end
      if (res_req && res_room) begin
        ov_r    <= 1'b1;
        ok_r    <= kind_fix;
        oval_r  <= ValueW'(sel_val);
        odep_r  <= 7'(count);
        olast_r <= res_last;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = ok_r;
  assign out_tdata  = {1'b0, odep_r, oval_r};
  assign out_tlast  = olast_r;

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: stream testbench for the Forth data stack executor
// Drives words from a queue, predicts every result with a local stack model
// and checks each output item in order, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
  import fdse_pkg::*;

  localparam int Depth = 64;
  localparam int CycleLimit = 2000000;

  typedef struct packed {
    logic [4:0]  mode;
    logic [31:0] lit;
  } word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic [6:0]  depth;
    logic        last;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic [4:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [2:0] out_tuser;
  logic out_tlast;

  forth_data_stack_executor uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #4 clk = ~clk;

  word_t word_q[$];
  res_t  expected_q[$];
  logic [31:0] stk[Depth];
  int unsigned stk_n = 0;
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;     // no idling in the last part
  bit hold_out = 1'b0;  // long receiver hold-off
  int in_gap = 0;
  int out_gap = 0;

  function automatic void spush(logic [31:0] v);
    if (stk_n < Depth) begin
      stk[stk_n] = v;
      stk_n++;
    end
  endfunction

  function automatic logic [31:0] spop();
    if (stk_n == 0) return '0;
    stk_n--;
    return stk[stk_n];
  endfunction

  function automatic void add_res(logic [2:0] k, logic [31:0] v, bit l);
    res_t r;
    r.kind = k; r.value = v; r.depth = 7'(stk_n); r.last = l;
    expected_q.push_back(r);
  endfunction

  // execute one word on the local stack and queue its results
  function automatic void predict_word(word_t w);
    logic [31:0] a, b, c;
    int unsigned i;
    int n;
    case (w.mode)
      W_LIT:  spush(w.lit);
      W_PRT:  begin a = spop(); add_res(K_PRINT, a, 1); return; end
      W_DROP: a = spop();
      W_DUP:  begin a = spop(); spush(a); spush(a); end
      W_SWAP: begin a = spop(); b = spop(); spush(a); spush(b); end
      W_OVER: begin a = spop(); b = spop(); spush(b); spush(a); spush(b); end
      W_ROT:  begin
        a = spop(); b = spop(); c = spop(); spush(b); spush(a); spush(c);
      end
      W_ADD:  begin a = spop(); b = spop(); spush(b + a); end
      W_SUB:  begin a = spop(); b = spop(); spush(b - a); end
      W_MUL:  begin a = spop(); b = spop(); spush(b * a); end
      W_DIV:  begin
        a = spop();
        if (a == 0) spush('0);
        else begin
          b = spop();
          if (a == '1) spush(-b);
          else spush($signed(b) / $signed(a));
        end
      end
      W_EQ:   begin a = spop(); b = spop(); spush(a == b ? '1 : '0); end
      W_LT:   begin a = spop(); b = spop(); spush($signed(b) < $signed(a) ? '1 : '0); end
      W_GT:   begin a = spop(); b = spop(); spush($signed(b) > $signed(a) ? '1 : '0); end
      W_DUMP: begin
        if (stk_n > 0) begin
          i = stk_n; n = 0;
          while (i > 0 && n < MaxResults) begin
            i--;
            n++;
            add_res(K_DUMP, stk[i], i == 0 || n == MaxResults);
          end
          return;
        end
      end
      W_EMIT: begin
        a = spop();
        add_res(($signed(a) > 0 && $signed(a) < 128) ? K_CHAR : K_SKIP, a, 1);
        return;
      end
      W_CR:   begin add_res(K_CR, '0, 1); return; end
      default: ;
    endcase
    add_res(K_DONE, '0, 1);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic word_t mk(logic [4:0] m, logic [31:0] v);
    word_t w;
    w.mode = m; w.lit = v;
    return w;
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_word(word_q.pop_front());
      end
      if (word_q.size() < 60) quiet <= 1'b1;
      if (in_tvalid && !in_tready) begin
        // hold the offered item until it is taken
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        in_gap <= $urandom_range(1, 12);
        in_tvalid <= 1'b0;
      end else if (word_q.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tuser <= word_q[0].mode;
        in_tdata <= word_q[0].lit;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected item", 32'(out_tuser), '0);
        end else begin
          want = expected_q.pop_front();
          if (out_tuser !== want.kind)
            report_mismatch("kind", 32'(out_tuser), 32'(want.kind));
          if (out_tdata[31:0] !== want.value)
            report_mismatch("value", out_tdata[31:0], want.value);
          if (out_tdata[38:32] !== want.depth)
            report_mismatch("depth", 32'(out_tdata[38:32]), 32'(want.depth));
          if (out_tlast !== want.last)
            report_mismatch("last", 32'(out_tlast), 32'(want.last));
        end
      end
      if (hold_out) out_tready <= 1'b0;
      else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(1, 12);
        out_tready <= 1'b0;
      end else out_tready <= 1'b1;
    end
    if (cycles > CycleLimit) begin
      $display("[forth_data_stack_executor] ERROR");
      $finish;
    end
  end

  // long hold-off of the receiver, counted in its own process
  initial begin
    int c;
    wait (rst_n);
    repeat (600) @(posedge clk);
    hold_out = 1'b1;
    for (c = 0; c < 400; c++) @(posedge clk);
    hold_out = 1'b0;
  end

  initial begin
    int i, r;
    logic [4:0] m;
    logic [31:0] v;
    // directed: extremes and special cases
    word_q.push_back(mk(W_PRT, 0));            // pop from empty
    word_q.push_back(mk(W_DUMP, 0));           // dump of empty stack
    word_q.push_back(mk(W_LIT, 32'h8000_0000));
    word_q.push_back(mk(W_LIT, 32'hFFFF_FFFF));
    word_q.push_back(mk(W_DIV, 0));            // most negative / -1
    word_q.push_back(mk(W_DUP, 0));
    word_q.push_back(mk(W_LIT, 0));
    word_q.push_back(mk(W_DIV, 0));            // divide by zero
    word_q.push_back(mk(W_LIT, 32'h7FFF_FFFF));
    word_q.push_back(mk(W_LIT, 7));
    word_q.push_back(mk(W_OVER, 0));
    word_q.push_back(mk(W_ROT, 0));
    word_q.push_back(mk(W_SWAP, 0));
    word_q.push_back(mk(W_ADD, 0));
    word_q.push_back(mk(W_SUB, 0));
    word_q.push_back(mk(W_MUL, 0));
    word_q.push_back(mk(W_EQ, 0));
    word_q.push_back(mk(W_LT, 0));
    word_q.push_back(mk(W_GT, 0));
    word_q.push_back(mk(W_LIT, 65));
    word_q.push_back(mk(W_EMIT, 0));
    word_q.push_back(mk(W_LIT, 200));
    word_q.push_back(mk(W_EMIT, 0));          // emit out of range
    word_q.push_back(mk(W_CR, 0));
    word_q.push_back(mk(5'd31, 32'hFFFF_FFFF)); // unknown word
    // fill past full, then dump the whole stack
    for (i = 0; i < 66; i++) word_q.push_back(mk(W_LIT, $urandom));
    word_q.push_back(mk(W_DUMP, 0));
    word_q.push_back(mk(W_DROP, 0));
    for (i = 0; i < 260; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) m = W_LIT;
      else if (r < 95) m = 5'($urandom_range(1, 16));
      else m = 5'($urandom_range(17, 31));
      case ($urandom_range(0, 3))
        0: v = $urandom;
        1: v = 32'($signed($urandom_range(0, 20)) - 10);
        2: v = $urandom_range(0, 130);
        default: v = {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom)};
      endcase
      word_q.push_back(mk(m, v));
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (word_q.size() != 0 || (in_tvalid && in_tready)) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("[forth_data_stack_executor] OK");
    end else begin
      $display("[forth_data_stack_executor] ERROR");
    end
    $finish;
  end
endmodule
